// ===== hw/rtl/cau_pkg.sv =====
// ----------------------------------------------------------------------------
// cau_pkg
// Shared constants, types and helpers of the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

  // Fraction bits of the Q format.
  localparam int FRAC_BITS = 8;
  // Quotient bits resolved by the divider; larger quotients saturate anyway.
  localparam int QB     = 17;
  localparam int PROD_W = 32;
  localparam int DIR_W  = 34;
  localparam int DEN_W  = 32;
  localparam int MAG_W  = 33 + FRAC_BITS;
  localparam int CMP_W  = MAG_W + QB + DEN_W;

  // Command codes.
  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_SUB = 2'd1;
  localparam logic [1:0] CMD_MUL = 2'd2;
  localparam logic [1:0] CMD_DIV = 2'd3;

  typedef struct packed {
    logic signed [15:0] val;
    logic               ovf;
  } sat_t;

  // One request moving through the divider stages.
  typedef struct packed {
    logic [1:0]               cmd;
    logic signed [DIR_W-1:0]  dir_re;
    logic signed [DIR_W-1:0]  dir_im;
    logic                     dbz;
    logic [DEN_W-1:0]         den;
    logic                     neg_re;
    logic                     neg_im;
    logic                     ovf_re;
    logic                     ovf_im;
    logic [MAG_W-1:0]         rem_re;
    logic [MAG_W-1:0]         rem_im;
    logic [QB-1:0]            q_re;
    logic [QB-1:0]            q_im;
  } div_t;

  // Clamp a wide signed value to the 16-bit range.
  function automatic sat_t sat16(input logic signed [DIR_W-1:0] v);
    sat_t r;
    if (v > DIR_W'(signed'(32767))) begin
      r.val = 16'sd32767;
      r.ovf = 1'b1;
    end else if (v < -DIR_W'(signed'(32768))) begin
      r.val = -16'sd32768;
      r.ovf = 1'b1;
    end else begin
      r.val = v[15:0];
      r.ovf = 1'b0;
    end
    return r;
  endfunction

  // Signed value of a divider result, forced past the limit on quotient overflow.
  function automatic logic signed [DIR_W-1:0] div_val(input logic neg, input logic ovf,
                                                      input logic [QB-1:0] q);
    logic signed [DIR_W-1:0] m;
    m = ovf ? (DIR_W'(1) <<< QB) : signed'(DIR_W'(q));
    return neg ? -m : m;
  endfunction

endpackage

// ===== hw/rtl/cau_req_if.sv =====
// ----------------------------------------------------------------------------
// cau_req_if
// Request channel: command and two complex operands.
// ----------------------------------------------------------------------------
interface cau_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic signed [15:0] a_real;
  logic signed [15:0] a_imag;
  logic signed [15:0] b_real;
  logic signed [15:0] b_imag;

  modport source (output valid, command, a_real, a_imag, b_real, b_imag, input ready);
  modport sink   (input valid, command, a_real, a_imag, b_real, b_imag, output ready);
endinterface

// ===== hw/rtl/cau_rsp_if.sv =====
// ----------------------------------------------------------------------------
// cau_rsp_if
// Result channel: saturated complex result and status flags.
// ----------------------------------------------------------------------------
interface cau_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] result_real;
  logic signed [15:0] result_imag;
  logic               overflow;
  logic               divide_by_zero;

  modport source (output valid, result_real, result_imag, overflow, divide_by_zero,
                  input ready);
  modport sink   (input valid, result_real, result_imag, overflow, divide_by_zero,
                  output ready);
endinterface

// ===== hw/rtl/complex_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Pipelined complex add, subtract, multiply and divide on Q8.8 operands.
// ----------------------------------------------------------------------------
// The unit accepts one request every cycle while ready is high and offers each
// result in order. The path runs through an input stage, a multiplier stage,
// a sum stage and a sign/range stage, then a restoring divider unrolled into
// one pipeline stage per quotient bit (17 stages); an output stage saturates.
// All requests take the same path. A stall at the result side holds the whole
// pipeline, and ready drops only while the final stage holds a result that is
// not taken.
module complex_arithmetic_unit (
  input  logic     clk_i,
  input  logic     rst_ni,
  cau_req_if.sink  req_i,
  cau_rsp_if.source rsp_o
);

  localparam int PW = cau_pkg::PROD_W;
  localparam int DW = cau_pkg::DIR_W;
  localparam int QB = cau_pkg::QB;
  localparam int MW = cau_pkg::MAG_W;
  localparam int CW = cau_pkg::CMP_W;

  logic en;

  // Input stage.
  logic               v1_q;
  logic [1:0]         cmd1_q;
  logic signed [15:0] ar1_q, ai1_q, br1_q, bi1_q;

  // Product stage.
  logic                 v2_q;
  logic [1:0]           cmd2_q;
  logic signed [PW-1:0] prr_q, pii_q, pri_q, pir_q, qrr_q, qii_q;
  logic signed [16:0]   sre_q, sim_q;

  // Sum stage.
  logic                  v3_q;
  logic [1:0]            cmd3_q;
  logic signed [DW-1:0]  dir_re_q, dir_im_q, num_re_q, num_im_q;
  logic [cau_pkg::DEN_W-1:0] den_q;

  // Divider stages, index 0 is the sign/range stage.
  logic          vd_q [QB+1];
  cau_pkg::div_t dv_q [QB+1];

  // Output stage.
  logic               vo_q;
  logic signed [15:0] re_q, im_q;
  logic               ovf_q, dbz_q;

  assign en          = !vo_q || rsp_o.ready;
  assign req_i.ready = en;

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
      for (int i = 0; i <= QB; i++) vd_q[i] <= 1'b0;
    end else if (en) begin
      v1_q <= req_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      vd_q[0] <= v3_q;
      for (int i = 1; i <= QB; i++) vd_q[i] <= vd_q[i-1];
      vo_q <= vd_q[QB];
    end
  end

  // Input, product and sum stages.
  always_ff @(posedge clk_i) begin
    if (en) begin
      cmd1_q <= req_i.command;
      ar1_q  <= req_i.a_real;
      ai1_q  <= req_i.a_imag;
      br1_q  <= req_i.b_real;
      bi1_q  <= req_i.b_imag;

      cmd2_q <= cmd1_q;
      prr_q  <= ar1_q * br1_q;
      pii_q  <= ai1_q * bi1_q;
      pri_q  <= ar1_q * bi1_q;
      pir_q  <= ai1_q * br1_q;
      qrr_q  <= br1_q * br1_q;
      qii_q  <= bi1_q * bi1_q;
      if (cmd1_q == cau_pkg::CMD_SUB) begin
        sre_q <= 17'(ar1_q) - 17'(br1_q);
        sim_q <= 17'(ai1_q) - 17'(bi1_q);
      end else begin
        sre_q <= 17'(ar1_q) + 17'(br1_q);
        sim_q <= 17'(ai1_q) + 17'(bi1_q);
      end

      cmd3_q <= cmd2_q;
      if (cmd2_q == cau_pkg::CMD_MUL) begin
        dir_re_q <= (DW'(prr_q) - DW'(pii_q)) >>> cau_pkg::FRAC_BITS;
        dir_im_q <= (DW'(pri_q) + DW'(pir_q)) >>> cau_pkg::FRAC_BITS;
      end else begin
        dir_re_q <= DW'(sre_q);
        dir_im_q <= DW'(sim_q);
      end
      num_re_q <= DW'(prr_q) + DW'(pii_q);
      num_im_q <= DW'(pir_q) - DW'(pri_q);
      den_q    <= qrr_q[cau_pkg::DEN_W-1:0] + qii_q[cau_pkg::DEN_W-1:0];
    end
  end

  // Sign and range stage: magnitudes, scaling and quotient overflow check.
  logic signed [DW-1:0] mre, mim;
  logic [MW-1:0]        rre, rim;
  logic [CW-1:0]        dtop;

  always_comb begin
    mre  = num_re_q[DW-1] ? -num_re_q : num_re_q;
    mim  = num_im_q[DW-1] ? -num_im_q : num_im_q;
    rre  = {mre[32:0], {cau_pkg::FRAC_BITS{1'b0}}};
    rim  = {mim[32:0], {cau_pkg::FRAC_BITS{1'b0}}};
    dtop = CW'(den_q) << QB;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_q[0].cmd    <= cmd3_q;
      dv_q[0].dir_re <= dir_re_q;
      dv_q[0].dir_im <= dir_im_q;
      dv_q[0].dbz    <= (cmd3_q == cau_pkg::CMD_DIV) && (den_q == '0);
      dv_q[0].den    <= den_q;
      dv_q[0].neg_re <= num_re_q[DW-1];
      dv_q[0].neg_im <= num_im_q[DW-1];
      dv_q[0].ovf_re <= CW'(rre) >= dtop;
      dv_q[0].ovf_im <= CW'(rim) >= dtop;
      dv_q[0].rem_re <= rre;
      dv_q[0].rem_im <= rim;
      dv_q[0].q_re   <= '0;
      dv_q[0].q_im   <= '0;
    end
  end

  // Restoring divider, one quotient bit per stage, most significant first.
  for (genvar j = 1; j <= QB; j++) begin : g_div
    localparam int B = QB - j;
    logic [CW-1:0]  dsh;
    logic           tre, tim;
    cau_pkg::div_t  nx;

    always_comb begin
      nx  = dv_q[j-1];
      dsh = CW'(dv_q[j-1].den) << B;
      tre = CW'(dv_q[j-1].rem_re) >= dsh;
      tim = CW'(dv_q[j-1].rem_im) >= dsh;
      if (tre) nx.rem_re = dv_q[j-1].rem_re - dsh[MW-1:0];
      if (tim) nx.rem_im = dv_q[j-1].rem_im - dsh[MW-1:0];
      nx.q_re[B] = tre;
      nx.q_im[B] = tim;
    end

    always_ff @(posedge clk_i) begin
      if (en) dv_q[j] <= nx;
    end
  end

  // Output stage: result select and saturation.
  cau_pkg::div_t        dl;
  cau_pkg::sat_t        sre, sim;
  logic signed [DW-1:0] vre, vim;

  always_comb begin
    dl = dv_q[QB];
    if (dl.cmd == cau_pkg::CMD_DIV) begin
      if (dl.dbz) begin
        vre = '0;
        vim = '0;
      end else begin
        vre = cau_pkg::div_val(dl.neg_re, dl.ovf_re, dl.q_re);
        vim = cau_pkg::div_val(dl.neg_im, dl.ovf_im, dl.q_im);
      end
    end else begin
      vre = dl.dir_re;
      vim = dl.dir_im;
    end
    sre = cau_pkg::sat16(vre);
    sim = cau_pkg::sat16(vim);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      re_q  <= sre.val;
      im_q  <= sim.val;
      ovf_q <= sre.ovf || sim.ovf;
      dbz_q <= dl.dbz;
    end
  end

  assign rsp_o.valid          = vo_q;
  assign rsp_o.result_real    = re_q;
  assign rsp_o.result_imag    = im_q;
  assign rsp_o.overflow       = ovf_q;
  assign rsp_o.divide_by_zero = dbz_q;

endmodule

// ===== hw/rtl/cau_checker.sv =====
// ----------------------------------------------------------------------------
// cau_checker
// Port-level checks of the complex arithmetic unit, bound to the top level.
// ----------------------------------------------------------------------------
module cau_checker (
  input logic       clk_i,
  input logic       rst_ni,
  cau_req_if.sink   req_i,
  cau_rsp_if.source rsp_o
);

  // A result that is not taken stays offered.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.ready |=> rsp_o.valid)
    else $error("result dropped while stalled");

  // A zero divisor gives a zero result without overflow.
  a_dbz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.divide_by_zero |->
      rsp_o.result_real == 16'sd0 && rsp_o.result_imag == 16'sd0 && !rsp_o.overflow)
    else $error("divide by zero result not clean");

  // Overflow means at least one part sits at a limit.
  a_ovf_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.overflow |->
      rsp_o.result_real == 16'sd32767 || rsp_o.result_real == -16'sd32768 ||
      rsp_o.result_imag == 16'sd32767 || rsp_o.result_imag == -16'sd32768)
    else $error("overflow without saturated part");

  // A new result only appears once the pipeline has advanced.
  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_o.valid) |-> $past(req_i.ready))
    else $error("result appeared during a stall");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .req_i  (req_i),
  .rsp_o  (rsp_o)
);
